### rtl/mvbs_pkg.sv
// shared types and constants for the majority vote bit slicer
package mvbs_pkg;

  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned BITS_W    = $clog2(WORD_BITS + 1);
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned THR_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]     THRESHOLD_RST = THR_W'(1638);
  localparam logic [TICK_W-1:0]    SPB_RST       = TICK_W'(32);
  localparam logic [WORD_BITS-1:0] OWN_CODE_RST  = '0;

  localparam logic [WORD_BITS-1:0] ALERT_A = 16'hAAAA;
  localparam logic [WORD_BITS-1:0] ALERT_B = 16'h5555;
  localparam logic [WORD_BITS-1:0] TEST_A  = 16'hFF00;
  localparam logic [WORD_BITS-1:0] TEST_B  = 16'h00FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SPB       = 2'd1,
    REG_OWN_CODE  = 2'd2
  } mvbs_reg_e;

  typedef struct packed {
    logic personal;
    logic alert;
    logic test;
  } mvbs_match_t;

  typedef struct packed {
    logic                 frame_done;
    logic [WORD_BITS-1:0] received_word;
    logic                 personal_hit;
    logic                 alert_hit;
    logic                 test_hit;
    logic                 detecting;
  } mvbs_result_t;

endpackage

### rtl/mvbs_if.sv
// valid/ready channel interfaces for samples, results and configuration writes
interface mvbs_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface mvbs_result_if;
  logic        valid;
  logic        ready;
  logic        frame_done;
  logic [15:0] received_word;
  logic        personal_hit;
  logic        alert_hit;
  logic        test_hit;
  logic        detecting;

  modport source (output valid, output frame_done, output received_word,
                  output personal_hit, output alert_hit, output test_hit,
                  output detecting, input ready);
  modport sink   (input valid, input frame_done, input received_word,
                  input personal_hit, input alert_hit, input test_hit,
                  input detecting, output ready);
endinterface

interface mvbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mvbs_matcher.sv
// word matcher: personal, alert and test code compares
module mvbs_matcher
  import mvbs_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] own_code_i,
  output mvbs_match_t          match_o
);

  always_comb begin
    match_o.personal = (word_i == own_code_i);
    match_o.alert    = (word_i == ALERT_A) || (word_i == ALERT_B);
    match_o.test     = (word_i == TEST_A) || (word_i == TEST_B);
  end

endmodule

### rtl/majority_vote_bit_slicer_word_matcher.sv
// top level: majority vote bit slicer with 16-bit word matcher
// a sample is held in the sample register, then its result in the result register
// throughput: one sample per cycle while results are accepted; a waiting result
// holds the sample register, which then blocks the next sample
// reset: reception idle, counters and word cleared, registers at defaults
module majority_vote_bit_slicer_word_matcher
  import mvbs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mvbs_sample_if.sink  sample_i,
  mvbs_result_if.source result_o,
  mvbs_cfg_if.sink     cfg_i
);

  localparam int unsigned CmpW = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

  logic [THR_W-1:0]     threshold_q;
  logic [TICK_W-1:0]    spb_q;
  logic [WORD_BITS-1:0] own_code_q;

  logic                 s1_valid_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic                 out_valid_q;
  mvbs_result_t         res_q, res_d;

  logic                   active_q, active_d;
  logic [TICK_W-1:0]      tick_q, tick_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d, low_q, low_d, band_q, band_d;
  logic [BITS_W-1:0]      bits_q, bits_d;
  logic [WORD_BITS-1:0]   word_q, word_d;

  logic                   advance;
  logic                   is_high, is_low;
  logic signed [SAMPLE_W:0] s_ext, thr_ext;
  logic [CmpW-1:0]        high_c, low_c, band_c, half_c;
  logic                   done;
  logic [WORD_BITS-1:0]   done_word;
  mvbs_match_t            match;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      spb_q       <= SPB_RST;
      own_code_q  <= OWN_CODE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_THRESHOLD: threshold_q <= cfg_i.data[THR_W-1:0];
        REG_SPB:       spb_q       <= cfg_i.data[TICK_W-1:0];
        REG_OWN_CODE:  own_code_q  <= cfg_i.data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance        = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      sample_q <= sample_i.sample_in;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // slicer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tick_q   <= '0;
      high_q   <= '0;
      low_q    <= '0;
      band_q   <= '0;
      bits_q   <= '0;
      word_q   <= '0;
    end else if (advance) begin
      active_q <= active_d;
      tick_q   <= tick_d;
      high_q   <= high_d;
      low_q    <= low_d;
      band_q   <= band_d;
      bits_q   <= bits_d;
      word_q   <= word_d;
    end
  end

  // sample classification
  always_comb begin
    s_ext   = {sample_q[SAMPLE_W-1], sample_q};
    thr_ext = {2'b00, threshold_q};
    is_high = (s_ext >= thr_ext);
    is_low  = (s_ext <= -thr_ext);
  end

  always_comb begin
    high_c = CmpW'(high_q);
    low_c  = CmpW'(low_q);
    band_c = CmpW'(band_q);
    half_c = CmpW'(spb_q[TICK_W-1:1]);
  end

  // next state and result
  always_comb begin
    active_d  = active_q;
    tick_d    = tick_q;
    high_d    = high_q;
    low_d     = low_q;
    band_d    = band_q;
    bits_d    = bits_q;
    word_d    = word_q;
    done      = 1'b0;
    done_word = '0;

    if (!active_q) begin
      if (is_high || is_low) begin
        tick_d   = '0;
        active_d = 1'b1;
      end
    end else begin
      if (tick_q < spb_q) begin
        if (is_high && (high_q != '1)) begin
          high_d = high_q + 1'b1;
        end
        if (is_low && (low_q != '1)) begin
          low_d = low_q + 1'b1;
        end
        if (!is_high && !is_low && (band_q != '1)) begin
          band_d = band_q + 1'b1;
        end
      end
      if (tick_q == spb_q) begin
        if (high_c > low_c && high_c > band_c && high_c > half_c) begin
          word_d = {word_q[WORD_BITS-2:0], 1'b1};
          bits_d = bits_q + 1'b1;
        end else if (low_c > high_c && low_c > band_c && low_c > half_c) begin
          word_d = {word_q[WORD_BITS-2:0], 1'b0};
          bits_d = bits_q + 1'b1;
        end else if (band_c > low_c && band_c > high_c) begin
          active_d = 1'b0;
          word_d   = '0;
          bits_d   = '0;
        end
        high_d = '0;
        low_d  = '0;
        band_d = '0;
        tick_d = '0;
      end
    end
    tick_d = tick_d + 1'b1;

    if (bits_d == BITS_W'(WORD_BITS)) begin
      done      = 1'b1;
      done_word = word_d;
      active_d  = 1'b0;
      word_d    = '0;
      bits_d    = '0;
    end
  end

  mvbs_matcher u_matcher (
    .word_i     (done_word),
    .own_code_i (own_code_q),
    .match_o    (match)
  );

  always_comb begin
    res_d.frame_done    = done;
    res_d.received_word = done_word;
    res_d.personal_hit  = done && match.personal;
    res_d.alert_hit     = done && match.alert;
    res_d.test_hit      = done && match.test;
    res_d.detecting     = active_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.frame_done    = res_q.frame_done;
  assign result_o.received_word = res_q.received_word;
  assign result_o.personal_hit  = res_q.personal_hit;
  assign result_o.alert_hit     = res_q.alert_hit;
  assign result_o.test_hit      = res_q.test_hit;
  assign result_o.detecting     = res_q.detecting;

  // checks
  a_idle_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (high_q == '0 && low_q == '0 && band_q == '0 && bits_q == '0))
    else $error("counters not clear while idle");

  a_bits_below_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q < BITS_W'(WORD_BITS))
    else $error("bit count reached word length in state");

  a_done_ends_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> !res_q.detecting)
    else $error("frame completed but reception still marked active");

  a_word_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.frame_done |->
      (res_q.received_word == '0 && !res_q.personal_hit &&
       !res_q.alert_hit && !res_q.test_hit))
    else $error("result word or flags set without a completed frame");

  a_advance_updates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced sample produced no result");

endmodule

### sim/tb_majority_vote_bit_slicer_word_matcher.sv
// self-checking testbench for the majority vote bit slicer and word matcher
`timescale 1ns / 100ps

module tb_majority_vote_bit_slicer_word_matcher;
  import mvbs_pkg::*;

  localparam int unsigned CNT_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int FLIP_CLEAN = 4;
  localparam int FLIP_ROUGH = 40;
  localparam int NO_ABORT = -1;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_ITEMS = 1100;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mvbs_sample_if smp_if ();
  mvbs_result_if res_if ();
  mvbs_cfg_if    cfg_if ();

  majority_vote_bit_slicer_word_matcher #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(smp_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // slicer model state and registers
  logic [THR_W-1:0]     thr_r;
  logic [TICK_W-1:0]    spb_r;
  logic [WORD_BITS-1:0] own_r;
  bit                   rx_active;
  logic [TICK_W-1:0]    tick_r;
  logic [CNT_W-1:0]     mark_cnt;
  logic [CNT_W-1:0]     space_cnt;
  logic [CNT_W-1:0]     band_cnt;
  logic [BITS_W-1:0]    bits_r;
  logic [WORD_BITS-1:0] word_r;

  logic [SAMPLE_W-1:0] sample_q[$];
  mvbs_result_t        frame_q[$];
  reg_write_t          reg_q[$];

  bit calm = 1'b0;
  bit tally = 1'b0;
  int random_pushed = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int words_done = 0;
  int regs_written = 0;
  int mismatches = 0;

  mvbs_result_t got;
  mvbs_result_t want;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic mvbs_result_t slice_sample(logic [SAMPLE_W-1:0] raw);
    int s;
    int t;
    bit hi;
    bit lo;
    logic [TICK_W-1:0] half;
    mvbs_result_t r;
    s = int'($signed(raw));
    t = int'(thr_r);
    hi = s >= t;
    lo = s <= -t;
    half = spb_r >> 1;
    r = '0;
    if (!rx_active) begin
      if (hi || lo) begin
        tick_r = '0;
        rx_active = 1'b1;
      end
    end else begin
      if (tick_r < spb_r) begin
        if (hi) mark_cnt = sat_inc(mark_cnt);
        if (lo) space_cnt = sat_inc(space_cnt);
        if (!hi && !lo) band_cnt = sat_inc(band_cnt);
      end
      if (tick_r == spb_r) begin
        if (bits_r < BITS_W'(WORD_BITS)) begin
          if (mark_cnt > space_cnt && mark_cnt > band_cnt && mark_cnt > half) begin
            word_r = {word_r[WORD_BITS-2:0], 1'b1};
            bits_r = bits_r + 1'b1;
          end else if (space_cnt > mark_cnt && space_cnt > band_cnt && space_cnt > half) begin
            word_r = {word_r[WORD_BITS-2:0], 1'b0};
            bits_r = bits_r + 1'b1;
          end else if (band_cnt > space_cnt && band_cnt > mark_cnt) begin
            rx_active = 1'b0;
            word_r = '0;
            bits_r = '0;
          end
        end
        mark_cnt = '0;
        space_cnt = '0;
        band_cnt = '0;
        tick_r = '0;
      end
    end
    tick_r = tick_r + 1'b1;
    if (bits_r == BITS_W'(WORD_BITS)) begin
      r.frame_done = 1'b1;
      r.received_word = word_r;
      r.personal_hit = (word_r == own_r);
      r.alert_hit = (word_r == ALERT_A) || (word_r == ALERT_B);
      r.test_hit = (word_r == TEST_A) || (word_r == TEST_B);
      rx_active = 1'b0;
      word_r = '0;
      bits_r = '0;
    end
    r.detecting = rx_active;
    return r;
  endfunction

  function automatic void apply_reg(reg_write_t w);
    case (w.idx)
      REG_THRESHOLD: thr_r = w.data[THR_W-1:0];
      REG_SPB:       spb_r = w.data[TICK_W-1:0];
      REG_OWN_CODE:  own_r = w.data;
      default: ;
    endcase
    regs_written++;
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
      smp_if.sample_in <= '0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        frame_q.push_back(slice_sample(smp_if.sample_in));
        samples_taken++;
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
          smp_if.valid <= 1'b1;
          smp_if.sample_in <= sample_q.pop_front();
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.frame_done = res_if.frame_done;
        got.received_word = res_if.received_word;
        got.personal_hit = res_if.personal_hit;
        got.alert_hit = res_if.alert_hit;
        got.test_hit = res_if.test_hit;
        got.detecting = res_if.detecting;
        results_seen++;
        if (frame_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with no sample pending: done=%0b word=%04h det=%0b",
                     results_seen, got.frame_done, got.received_word, got.detecting);
        end else begin
          want = frame_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d expected done=%0b word=%04h pers=%0b alert=%0b test=%0b det=%0b",
                       results_seen, want.frame_done, want.received_word, want.personal_hit,
                       want.alert_hit, want.test_hit, want.detecting);
              $display("result %0d actual   done=%0b word=%04h pers=%0b alert=%0b test=%0b det=%0b",
                       results_seen, got.frame_done, got.received_word, got.personal_hit,
                       got.alert_hit, got.test_hit, got.detecting);
            end
          end else if (got.frame_done) begin
            words_done++;
          end
        end
      end
      res_if.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  task automatic push_sample(logic [SAMPLE_W-1:0] v);
    sample_q.push_back(v);
    if (tally) random_pushed++;
  endtask

  function automatic logic [SAMPLE_W-1:0] mark_smp();
    int v;
    v = $urandom_range(32767, thr_r);
    return 16'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] space_smp();
    int v;
    v = $urandom_range(32768, thr_r);
    return 16'(-v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] band_smp();
    int v;
    if (thr_r == '0) return mark_smp();
    v = int'($urandom_range(2 * int'(thr_r) - 2)) - (int'(thr_r) - 1);
    return 16'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] class_smp(int c);
    case (c)
      0:       return space_smp();
      1:       return mark_smp();
      default: return band_smp();
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(7))
      0:       return own_r;
      1:       return $urandom_range(1) ? ALERT_A : ALERT_B;
      2:       return $urandom_range(1) ? TEST_A : TEST_B;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_frame(logic [WORD_BITS-1:0] word, int flip_pct, int abort_bit);
    int n;
    int c;
    n = int'(spb_r);
    push_sample($urandom_range(1) ? mark_smp() : space_smp());
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      for (int i = 0; i < n - 1; i++) begin
        c = int'(word[b]);
        if (abort_bit == b) c = 2;
        else if ($urandom_range(99) < flip_pct) c = $urandom_range(2);
        push_sample(class_smp(c));
      end
      push_sample(16'($urandom()));
    end
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++)
      push_sample($urandom_range(1) ? band_smp() : 16'($urandom()));
  endtask

  task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_q.push_back('{idx, data});
  endtask

  // called just after a rising edge
  task automatic program_regs();
    reg_write_t w;
    while (reg_q.size() > 0) begin
      w = reg_q.pop_front();
      cfg_if.valid <= 1'b1;
      cfg_if.index <= w.idx;
      cfg_if.data <= w.data;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      apply_reg(w);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || smp_if.valid || frame_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // bring a reception in progress back to idle: end the window with two in-band
  // samples, then if still active repeat with an in-band window of two
  task automatic flush_reception();
    bit keep;
    if (!rx_active) return;
    keep = tally;
    tally = 1'b0;
    if (thr_r == '0) queue_reg(REG_THRESHOLD, 16'(THRESHOLD_RST));
    queue_reg(REG_SPB, 16'((int'(tick_r) + 1) & 1023));
    program_regs();
    @(negedge clk_i);
    push_sample(band_smp());
    push_sample(band_smp());
    settle();
    if (rx_active) begin
      queue_reg(REG_SPB, 16'd2);
      program_regs();
      @(negedge clk_i);
      push_sample(band_smp());
      push_sample(band_smp());
      settle();
    end
    tally = keep;
  endtask

  task automatic pick_config(bit all_regs);
    int pick;
    logic [THR_W-1:0] thr;
    logic [TICK_W-1:0] spb;
    if (all_regs || $urandom_range(1)) begin
      pick = $urandom_range(9);
      if (pick <= 5) thr = THR_W'($urandom_range(6000, 300));
      else if (pick == 6) thr = '0;
      else if (pick == 7) thr = '1;
      else thr = THR_W'($urandom_range(32767));
      queue_reg(REG_THRESHOLD, {1'($urandom_range(1)), thr});
    end
    if (all_regs || $urandom_range(1)) begin
      pick = $urandom_range(19);
      if (pick <= 13) spb = TICK_W'($urandom_range(6, 3));
      else if (pick <= 15) spb = TICK_W'($urandom_range(16, 7));
      else if (pick == 16) spb = 10'd2;
      else if (pick == 17) spb = TICK_W'($urandom_range(1));
      else if (pick == 18) spb = '1;
      else spb = TICK_W'($urandom_range(1023));
      queue_reg(REG_SPB, {6'($urandom()), spb});
    end
    if (all_regs || $urandom_range(3) == 0) begin
      pick = $urandom_range(5);
      queue_reg(REG_OWN_CODE, (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom()));
    end
  endtask

  task automatic random_phase();
    int roll;
    int n;
    flush_reception();
    if ($urandom_range(1)) pick_config(1'b0);
    program_regs();
    @(negedge clk_i);
    calm = (random_pushed >= 300) && (random_pushed < 650);
    roll = $urandom_range(99);
    if (spb_r >= 3 && spb_r <= 16 && roll < 85) begin
      n = (roll < 65) ? $urandom_range(3, 1) : $urandom_range(2, 1);
      for (int f = 0; f < n; f++) begin
        if (thr_r != '0)
          for (int k = $urandom_range(4); k > 0; k--) push_sample(band_smp());
        if (roll < 65) add_frame(pick_word(), FLIP_CLEAN, NO_ABORT);
        else add_frame(pick_word(), FLIP_ROUGH,
                       $urandom_range(1) ? NO_ABORT : int'($urandom_range(WORD_BITS - 1)));
      end
    end else begin
      add_noise($urandom_range(60, 10));
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    thr_r = THRESHOLD_RST;
    spb_r = SPB_RST;
    own_r = OWN_CODE_RST;
    rx_active = 1'b0;
    tick_r = '0;
    mark_cnt = '0;
    space_cnt = '0;
    band_cnt = '0;
    bits_r = '0;
    word_r = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // short window: exact-threshold triggers, no majority above half, in-band aborts
    queue_reg(REG_SPB, 16'd2);
    program_regs();
    @(negedge clk_i);
    push_sample(16'(1637));
    push_sample(16'(-1637));
    push_sample(16'(0));
    push_sample(16'(1638));
    push_sample(16'(32767));
    push_sample(16'(-32768));
    push_sample(16'(-1638));
    push_sample(16'(0));
    push_sample(16'(5));
    push_sample(16'(7));
    push_sample(16'(-1638));
    push_sample(16'(100));
    push_sample(16'(32767));
    settle();

    // zero threshold: zero triggers and counts as both mark and space
    queue_reg(REG_THRESHOLD, 16'h0000);
    program_regs();
    @(negedge clk_i);
    push_sample(16'(0));
    push_sample(16'(0));
    push_sample(16'(0));
    push_sample(16'(-1));
    settle();

    // full-scale threshold and a window change during reception
    queue_reg(REG_THRESHOLD, 16'h7FFF);
    queue_reg(REG_SPB, 16'd3);
    program_regs();
    @(negedge clk_i);
    push_sample(16'(32766));
    push_sample(16'(-32767));
    push_sample(16'(-32768));
    push_sample(16'(32767));
    push_sample(16'(0));
    settle();

    queue_reg(REG_SPARE, 16'($urandom()));
    pick_config(1'b1);
    program_regs();
    repeat (2) @(posedge clk_i);
    tally = 1'b1;
    while (random_pushed < RANDOM_ITEMS) begin
      random_phase();
    end
    calm = 1'b0;
    settle();
    repeat (10) @(posedge clk_i);

    $display("covered %0d samples and %0d results, %0d completed words, %0d register writes",
             samples_taken, results_seen, words_done, regs_written);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("majority_vote_bit_slicer_word_matcher regression: pass");
    end else begin
      $display("majority_vote_bit_slicer_word_matcher regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d samples queued and %0d results outstanding",
             sample_q.size(), frame_q.size());
    $display("majority_vote_bit_slicer_word_matcher regression: fail");
    $finish;
  end

endmodule
